FILE: sv/stlim_pkg.sv
package stlim_pkg;

  // map geometry
  localparam int MAP_ENTRIES = 3;
  localparam int SLOTS       = 3;
  localparam int ENT_W       = 2;

  // field widths
  localparam int SPD_W  = 14;
  localparam int CUR_W  = 13;
  localparam int TRQ_W  = 14;
  localparam int REQ_W  = 16;
  localparam int MSPD_W = 15;
  localparam int CFG_W  = 14;
  localparam int IDX_W  = 3;

  // serial arithmetic units
  localparam int OP_W   = 14;
  localparam int STEPS  = OP_W;
  localparam int STEP_W = $clog2(STEPS);

  localparam logic [TRQ_W-1:0] TORQUE_FULL = TRQ_W'(10000);

  // 14140/4244 reduced by four
  localparam int CEIL_NUM = 14140 / 4;
  localparam int CEIL_DEN = 4244 / 4;
  // largest current whose ceiling stays at or below full torque
  localparam int CUR_SAT  = ((10000 + 1) * CEIL_DEN - 1) / CEIL_NUM;

  // default map
  localparam logic [SPD_W-1:0] DFLT_SPD0 = SPD_W'(0);
  localparam logic [SPD_W-1:0] DFLT_SPD1 = SPD_W'(6000);
  localparam logic [CUR_W-1:0] DFLT_CUR  = CUR_W'(3001);

  // register reset values
  localparam logic [ENT_W-1:0] RST_ENTRIES = ENT_W'(2);
  localparam logic [SPD_W-1:0] RST_SPD0    = SPD_W'(0);
  localparam logic [SPD_W-1:0] RST_SPD1    = SPD_W'(6000);
  localparam logic [SPD_W-1:0] RST_SPD2    = SPD_W'(16383);
  localparam logic [CUR_W-1:0] RST_CUR     = CUR_W'(3001);

  typedef enum logic [IDX_W-1:0] {
    REG_ENABLE  = 3'd0,
    REG_ENTRIES = 3'd1,
    REG_SPD0    = 3'd2,
    REG_SPD1    = 3'd3,
    REG_SPD2    = 3'd4,
    REG_CUR0    = 3'd5,
    REG_CUR1    = 3'd6,
    REG_CUR2    = 3'd7
  } reg_idx_e;

  typedef logic [SPD_W-1:0] spd_t;
  typedef logic [CUR_W-1:0] cur_t;

  // effective map after the breakpoint check
  typedef struct packed {
    logic                 enable;
    logic                 rejected;
    logic                 three;
    spd_t [SLOTS-1:0]     sp;
    cur_t [SLOTS-1:0]     cu;
  } map_t;

endpackage

FILE: sv/stlim_if.sv
interface stlim_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [stlim_pkg::REQ_W-1:0]  requested_torque;
  logic signed [stlim_pkg::MSPD_W-1:0] motor_speed;

  modport source (output valid, requested_torque, motor_speed, input ready);
  modport sink (input valid, requested_torque, motor_speed, output ready);
endinterface

interface stlim_out_if;
  logic                         valid;
  logic                         ready;
  logic [stlim_pkg::TRQ_W-1:0]  torque_limit;
  logic [stlim_pkg::TRQ_W-1:0]  torque_ceiling;
  logic                         map_rejected;

  modport source (output valid, torque_limit, torque_ceiling, map_rejected, input ready);
  modport sink (input valid, torque_limit, torque_ceiling, map_rejected, output ready);
endinterface

FILE: sv/stlim_cfg.sv
module stlim_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [stlim_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [stlim_pkg::CFG_W-1:0]   cfg_data_i,
  output stlim_pkg::map_t               map_o
);
  import stlim_pkg::*;

  localparam logic [ENT_W-1:0] ENT_MIN  = ENT_W'(2);
  localparam logic [ENT_W-1:0] ENT_MAX  = ENT_W'(MAP_ENTRIES);
  localparam logic [ENT_W-1:0] ENT_FULL = ENT_W'(SLOTS);

  logic             enable_q;
  logic [ENT_W-1:0] entries_q;
  spd_t             sp_q [SLOTS];
  cur_t             cu_q [SLOTS];
  logic             count_bad;
  logic             order_bad;
  logic             rejected;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      entries_q <= RST_ENTRIES;
      sp_q[0]   <= RST_SPD0;
      sp_q[1]   <= RST_SPD1;
      sp_q[2]   <= RST_SPD2;
      cu_q[0]   <= RST_CUR;
      cu_q[1]   <= RST_CUR;
      cu_q[2]   <= RST_CUR;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_ENABLE:  enable_q  <= cfg_data_i[0];
        REG_ENTRIES: entries_q <= cfg_data_i[ENT_W-1:0];
        REG_SPD0:    sp_q[0]   <= cfg_data_i[SPD_W-1:0];
        REG_SPD1:    sp_q[1]   <= cfg_data_i[SPD_W-1:0];
        REG_SPD2:    sp_q[2]   <= cfg_data_i[SPD_W-1:0];
        REG_CUR0:    cu_q[0]   <= cfg_data_i[CUR_W-1:0];
        REG_CUR1:    cu_q[1]   <= cfg_data_i[CUR_W-1:0];
        REG_CUR2:    cu_q[2]   <= cfg_data_i[CUR_W-1:0];
        default: ;
      endcase
    end
  end

  // breakpoint check
  always_comb begin
    count_bad = (entries_q < ENT_MIN) || (entries_q > ENT_MAX);
    order_bad = (sp_q[1] <= sp_q[0]) || ((entries_q == ENT_FULL) && (sp_q[2] <= sp_q[1]));
    rejected  = count_bad || order_bad;
  end

  always_comb begin
    map_o.enable   = enable_q;
    map_o.rejected = rejected;
    map_o.three    = !rejected && (entries_q == ENT_FULL);
    if (rejected) begin
      map_o.sp[0] = DFLT_SPD0;
      map_o.sp[1] = DFLT_SPD1;
      map_o.sp[2] = DFLT_SPD1;
      map_o.cu[0] = DFLT_CUR;
      map_o.cu[1] = DFLT_CUR;
      map_o.cu[2] = DFLT_CUR;
    end else begin
      map_o.sp[0] = sp_q[0];
      map_o.sp[1] = sp_q[1];
      map_o.sp[2] = sp_q[2];
      map_o.cu[0] = cu_q[0];
      map_o.cu[1] = cu_q[1];
      map_o.cu[2] = cu_q[2];
    end
  end

endmodule

FILE: sv/stlim_smul.sv
module stlim_smul (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [stlim_pkg::OP_W-1:0]     a_i,
  input  logic [stlim_pkg::OP_W-1:0]     b_i,
  output logic [2*stlim_pkg::OP_W-1:0]   prod_o,
  output logic                           done_o
);
  import stlim_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [OP_W-1:0]   mcand_q;
  logic [OP_W-1:0]   hi_q;
  logic [OP_W-1:0]   lo_q;
  logic [OP_W:0]     sum;

  // one multiplier bit per cycle, lsb first
  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == STEP_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= a_i;
      hi_q    <= '0;
      lo_q    <= b_i;
    end else if (busy_q) begin
      hi_q <= sum[OP_W:1];
      lo_q <= {sum[0], lo_q[OP_W-1:1]};
    end
  end

  assign prod_o = {hi_q, lo_q};
  assign done_o = done_q;

endmodule

FILE: sv/stlim_sdiv.sv
module stlim_sdiv (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [2*stlim_pkg::OP_W-1:0]   num_i,
  input  logic [stlim_pkg::OP_W-1:0]     den_i,
  output logic [stlim_pkg::OP_W-1:0]     quo_o,
  output logic                           done_o
);
  import stlim_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [OP_W-1:0]   den_q;
  logic [OP_W-1:0]   rem_q;
  logic [OP_W-1:0]   sh_q;
  logic [OP_W:0]     trial;
  logic [OP_W:0]     diff;
  logic              fits;

  // restoring division, one quotient bit per cycle, msb first;
  // the upper half of the dividend must be below the divisor
  always_comb begin
    trial = {rem_q, sh_q[OP_W-1]};
    diff  = trial - {1'b0, den_q};
    fits  = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == STEP_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= num_i[2*OP_W-1:OP_W];
      sh_q  <= num_i[OP_W-1:0];
    end else if (busy_q) begin
      rem_q <= fits ? diff[OP_W-1:0] : trial[OP_W-1:0];
      sh_q  <= {sh_q[OP_W-2:0], fits};
    end
  end

  assign quo_o  = sh_q;
  assign done_o = done_q;

endmodule

FILE: sv/speed_mapped_torque_limiter_top.sv
// speed-mapped torque limiter, one result word for every input word
// a new input word is accepted only in idle, after the previous result is loaded
// into the result register; one 14-step serial multiplier and one 14-step serial
//   divider are each used twice per word (interpolation, then ceiling)
// reset: asynchronous active low, clears control and loads register reset values
module speed_mapped_torque_limiter_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [stlim_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [stlim_pkg::CFG_W-1:0]   cfg_data_i,
  stlim_in_if.sink                      in_i,
  stlim_out_if.source                   out_o
);
  import stlim_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_DIV1,
    ST_MUL2,
    ST_DIV2,
    ST_OUT
  } state_e;

  localparam logic [OP_W-1:0] SPAN_ONE = OP_W'(1);
  localparam logic [CUR_W-1:0] CUR_LIM = CUR_W'(CUR_SAT);

  state_e           state_q;
  map_t             map;

  // captured at accept (sat_q at the end of the first division)
  logic [TRQ_W-1:0] req_q;
  cur_t             clo_q;
  logic             neg_q;
  logic [OP_W-1:0]  span_q;
  logic             sat_q;

  // result register
  logic             out_valid_q;
  logic [TRQ_W-1:0] limit_q;
  logic [TRQ_W-1:0] ceil_q;
  logic             rej_q;

  // segment selection
  spd_t             spd;
  spd_t             last_sp;
  cur_t             last_cu;
  spd_t             seg_d;
  spd_t             seg_span;
  cur_t             seg_clo;
  cur_t             seg_chi;
  logic             seg_neg;
  cur_t             seg_mag;
  logic [TRQ_W-1:0] req_clamp;

  // serial units
  logic               accept;
  logic               mul_start;
  logic               mul_done;
  logic [OP_W-1:0]    mul_a;
  logic [OP_W-1:0]    mul_b;
  logic [2*OP_W-1:0]  prod;
  logic               div_start;
  logic               div_done;
  logic [OP_W-1:0]    div_den;
  logic [OP_W-1:0]    quo;
  cur_t               cur;
  logic [TRQ_W-1:0]   ceiling;
  logic [TRQ_W-1:0]   grant;
  logic               out_load;

  stlim_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .map_o      (map)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && (state_q == ST_IDLE);

  // negative speed counts as zero, request clamped to 0..full
  always_comb begin
    spd = in_i.motor_speed[MSPD_W-1] ? '0 : in_i.motor_speed[SPD_W-1:0];
    if (in_i.requested_torque[REQ_W-1]) begin
      req_clamp = '0;
    end else if (in_i.requested_torque[REQ_W-2:0] > (REQ_W-1)'(TORQUE_FULL)) begin
      req_clamp = TORQUE_FULL;
    end else begin
      req_clamp = in_i.requested_torque[TRQ_W-1:0];
    end
  end

  // pick the segment; outside the map the end current is held with a zero offset
  always_comb begin
    last_sp = map.three ? map.sp[2] : map.sp[1];
    last_cu = map.three ? map.cu[2] : map.cu[1];
    if (spd <= map.sp[0]) begin
      seg_clo  = map.cu[0];
      seg_chi  = map.cu[0];
      seg_d    = '0;
      seg_span = SPAN_ONE;
    end else if (spd >= last_sp) begin
      seg_clo  = last_cu;
      seg_chi  = last_cu;
      seg_d    = '0;
      seg_span = SPAN_ONE;
    end else if (map.three && (spd > map.sp[1])) begin
      // on an inner breakpoint the lower segment wins
      seg_clo  = map.cu[1];
      seg_chi  = map.cu[2];
      seg_d    = spd - map.sp[1];
      seg_span = map.sp[2] - map.sp[1];
    end else begin
      seg_clo  = map.cu[0];
      seg_chi  = map.cu[1];
      seg_d    = spd - map.sp[0];
      seg_span = map.sp[1] - map.sp[0];
    end
    seg_neg = seg_chi < seg_clo;
    seg_mag = seg_neg ? (seg_clo - seg_chi) : (seg_chi - seg_clo);
  end

  // interpolated current: magnitude quotient truncates toward zero
  assign cur = neg_q ? (clo_q - quo[CUR_W-1:0]) : (clo_q + quo[CUR_W-1:0]);

  // multiplier: offset times current step, then current times ceiling numerator
  always_comb begin
    mul_start = accept || ((state_q == ST_DIV1) && div_done);
    if (state_q == ST_IDLE) begin
      mul_a = seg_d;
      mul_b = OP_W'(seg_mag);
    end else begin
      mul_a = OP_W'(cur);
      mul_b = OP_W'(CEIL_NUM);
    end
  end

  // divider: by the segment span, then by the ceiling denominator
  always_comb begin
    div_start = mul_done && ((state_q == ST_MUL1) || (state_q == ST_MUL2));
    div_den   = (state_q == ST_MUL1) ? span_q : OP_W'(CEIL_DEN);
  end

  stlim_smul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (prod),
    .done_o  (mul_done)
  );

  stlim_sdiv u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod),
    .den_i   (div_den),
    .quo_o   (quo),
    .done_o  (div_done)
  );

  // ceiling saturates above the current limit, full torque when disabled
  always_comb begin
    ceiling  = (!map.enable || sat_q) ? TORQUE_FULL : quo;
    grant    = (req_q < ceiling) ? req_q : ceiling;
    out_load = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      req_q       <= '0;
      clo_q       <= '0;
      neg_q       <= 1'b0;
      span_q      <= '0;
      sat_q       <= 1'b0;
      limit_q     <= '0;
      ceil_q      <= '0;
      rej_q       <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            req_q   <= req_clamp;
            clo_q   <= seg_clo;
            neg_q   <= seg_neg;
            span_q  <= seg_span;
            state_q <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          if (mul_done) begin
            state_q <= ST_DIV1;
          end
        end
        ST_DIV1: begin
          if (div_done) begin
            sat_q   <= cur > CUR_LIM;
            state_q <= ST_MUL2;
          end
        end
        ST_MUL2: begin
          if (mul_done) begin
            state_q <= ST_DIV2;
          end
        end
        ST_DIV2: begin
          if (div_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          // result waits here only while the previous word is still held
          if (out_load) begin
            limit_q     <= grant;
            ceil_q      <= ceiling;
            rej_q       <= map.rejected;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.torque_limit   = limit_q;
  assign out_o.torque_ceiling = ceil_q;
  assign out_o.map_rejected   = rej_q;

  // the serial units are used one after the other, never started together
  a_start_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_start && div_start))
    else $error("multiplier and divider started together");

  a_done_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> ((state_q == ST_MUL1) || (state_q == ST_MUL2)))
    else $error("multiplier finished outside a multiply state");

  a_out_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((limit_q <= ceil_q) && (ceil_q <= TORQUE_FULL)))
    else $error("granted torque above ceiling or ceiling above full");

  a_load_next : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_q && (state_q == ST_IDLE)))
    else $error("result word not held after load");

endmodule
